// ----- src/urxwm_pkg.sv -----
// ----------------------------------------------------------------------------
// urxwm_pkg - shared types and constants of the UART rx watermark register block
// Function codes, register offsets, interrupt bits and the result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package urxwm_pkg;

	localparam int DATA_W      = 32;
	localparam int BYTE_W      = 8;
	localparam int LEVEL_LSB   = 16;
	localparam int LEVEL_W     = DATA_W - LEVEL_LSB;
	localparam int RX_DEPTH_DEF = 16;

	// interrupt enable / pending bit positions
	localparam int IE_TXWM_BIT = 0;
	localparam int IE_RXWM_BIT = 1;

	localparam logic [DATA_W-1:0] RX_EMPTY_WORD = 32'h8000_0000;
	localparam logic [DATA_W-1:0] IP_TXWM_WORD  = 32'h0000_0001;
	localparam logic [DATA_W-1:0] IP_RXWM_WORD  = 32'h0000_0002;

	typedef enum logic [1:0] {
		FUNC_READ    = 2'd0,
		FUNC_WRITE   = 2'd1,
		FUNC_RX_BYTE = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		REG_TXDATA = 3'd0,
		REG_RXDATA = 3'd1,
		REG_TXCTRL = 3'd2,
		REG_RXCTRL = 3'd3,
		REG_IE     = 3'd4,
		REG_IP     = 3'd5,
		REG_DIV    = 3'd6
	} reg_t;

	// FIFO command from the register decode to the cell chain
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [BYTE_W-1:0] data;
	} fifo_cmd_t;

	// one result, packed as it leaves on m_tdata (lowest field last here)
	typedef struct packed {
		logic              rx_dropped;
		logic              irq_condition;
		logic              kick_delayed;
		logic              kick_now;
		logic [DATA_W-1:0] read_data;
	} result_t;

endpackage

`default_nettype wire

// ----- src/urxwm_cell.sv -----
// ----------------------------------------------------------------------------
// urxwm_cell - one byte cell of the receive FIFO chain
// Shifts toward the head on a pop, loads the incoming byte when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module urxwm_cell (
	input  wire logic                         clk,
	input  wire logic                         shift,
	input  wire logic                         load,
	input  wire logic [urxwm_pkg::BYTE_W-1:0] shift_in,
	input  wire logic [urxwm_pkg::BYTE_W-1:0] load_data,
	output logic      [urxwm_pkg::BYTE_W-1:0] data_q
);

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= shift_in;
		end else if (load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

// ----- src/urxwm_chain.sv -----
// ----------------------------------------------------------------------------
// urxwm_chain - receive FIFO built as a row of shifting byte cells
// Head always sits in cell 0; a push lands in the cell at the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module urxwm_chain #(
	parameter int RX_DEPTH = urxwm_pkg::RX_DEPTH_DEF,
	localparam int CNT_W   = $clog2(RX_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire urxwm_pkg::fifo_cmd_t         cmd,
	output logic      [urxwm_pkg::BYTE_W-1:0] head,
	output logic      [CNT_W-1:0]             count,
	output logic                              full,
	output logic                              empty
);

	logic [urxwm_pkg::BYTE_W-1:0] link [RX_DEPTH+1];
	logic [CNT_W-1:0]             count_q;

	assign link[RX_DEPTH] = '0;

	for (genvar i = 0; i < RX_DEPTH; i++) begin : g_cell
		urxwm_cell u_cell (
			.clk       (clk),
			.shift     (cmd.pop),
			.load      (cmd.push && (count_q == CNT_W'(i))),
			.shift_in  (link[i+1]),
			.load_data (cmd.data),
			.data_q    (link[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end else if (cmd.push) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign head  = link[0];
	assign count = count_q;
	assign full  = (count_q == CNT_W'(RX_DEPTH));
	assign empty = (count_q == '0);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !full) else $error("push into full rx FIFO");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !empty) else $error("pop from empty rx FIFO");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("rx count did not drop after pop");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RX_DEPTH)) else $error("rx count beyond depth");

endmodule

`default_nettype wire

// ----- src/uart_register_block_rx_watermark_top.sv -----
// ----------------------------------------------------------------------------
// uart_register_block_rx_watermark_top - UART register file with rx byte FIFO
// Decodes bus reads, bus writes and byte arrivals, keeps the control
// registers and reports read data, interrupt kicks, the irq condition and dropped rx bytes.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: func; tdata: reg_index,
//          |     |                    |   write_data, rx_byte
//  m_*     | out | m_tvalid/m_tready  | tdata: read_data, kick_now,
//          |     |                    |   kick_delayed, irq_condition,
//          |     |                    |   rx_dropped
//
//  One request per clock while s_tready is high; decode, register update and
//  FIFO push/pop all finish in the accepting cycle, and the result is registered.
//  The result path is an output register plus one skid register, so a
//  request is still taken while one result waits; s_tready drops only
//  when both hold a result.
//  arst_n clears the control, enable and divisor registers, the FIFO fill count and both result valids.
//  FIFO cells hold no reset value; only filled cells are ever popped.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_block_rx_watermark_top #(
	parameter int RX_DEPTH = urxwm_pkg::RX_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [2:0] reg_index, [34:3] write_data, [42:35] rx_byte, [47:43] zero
	input  wire logic [47:0] s_tdata,
	// [1:0] func
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] read_data, [32] kick_now, [33] kick_delayed,
	// [34] irq_condition, [35] rx_dropped, [39:36] zero
	output logic [39:0]      m_tdata
);

	localparam int CNT_W = $clog2(RX_DEPTH + 1);
	localparam int DW    = urxwm_pkg::DATA_W;
	localparam int LSB   = urxwm_pkg::LEVEL_LSB;

	// request fields
	urxwm_pkg::func_t             func;
	urxwm_pkg::reg_t              reg_index;
	logic [DW-1:0]                write_data;
	logic [urxwm_pkg::BYTE_W-1:0] rx_byte;
	logic                         accept;

	assign func       = urxwm_pkg::func_t'(s_tuser);
	assign reg_index  = urxwm_pkg::reg_t'(s_tdata[2:0]);
	assign write_data = s_tdata[34:3];
	assign rx_byte    = s_tdata[42:35];

	// architectural registers
	logic [DW-1:0] tx_control_q, rx_control_q, int_enable_q, divisor_q;
	logic [DW-1:0] tx_control_n, rx_control_n, int_enable_n, divisor_n;

	// FIFO chain
	urxwm_pkg::fifo_cmd_t         cmd;
	logic [urxwm_pkg::BYTE_W-1:0] fifo_head;
	logic [CNT_W-1:0]             fifo_count;
	logic [CNT_W-1:0]             count_n;
	logic                         fifo_full, fifo_empty;

	// result path: output register and skid register
	urxwm_pkg::result_t res, out_q, skid_q;
	logic               out_valid_q, skid_valid_q;
	logic               out_free;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;

	urxwm_chain #(
		.RX_DEPTH (RX_DEPTH)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (fifo_head),
		.count  (fifo_count),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	// decode: read data, kicks, FIFO command and next register values
	always_comb begin
		logic notify;
		logic pop, push;

		notify       = int_enable_q[urxwm_pkg::IE_TXWM_BIT];
		pop          = 1'b0;
		push         = 1'b0;
		tx_control_n = tx_control_q;
		rx_control_n = rx_control_q;
		int_enable_n = int_enable_q;
		divisor_n    = divisor_q;
		res          = '0;

		unique case (func)
			urxwm_pkg::FUNC_READ: begin
				unique case (reg_index)
					urxwm_pkg::REG_RXDATA: begin
						if (fifo_empty || !int_enable_q[urxwm_pkg::IE_RXWM_BIT]) begin
							res.read_data = urxwm_pkg::RX_EMPTY_WORD;
						end else begin
							res.read_data = DW'(fifo_head);
							pop           = 1'b1;
						end
					end
					urxwm_pkg::REG_TXCTRL: res.read_data = tx_control_q;
					urxwm_pkg::REG_RXCTRL: res.read_data = rx_control_q;
					urxwm_pkg::REG_IE:     res.read_data = int_enable_q;
					urxwm_pkg::REG_IP: begin
						res.read_data = urxwm_pkg::IP_TXWM_WORD;
						if (DW'(fifo_count) > DW'(rx_control_q[DW-1:LSB])) begin
							res.read_data = res.read_data | urxwm_pkg::IP_RXWM_WORD;
						end
					end
					urxwm_pkg::REG_DIV:    res.read_data = divisor_q;
					default:               res.read_data = '0;
				endcase
				res.kick_now = notify;
			end
			urxwm_pkg::FUNC_WRITE: begin
				unique case (reg_index)
					urxwm_pkg::REG_TXCTRL: begin
						if (write_data[DW-1:LSB] < tx_control_q[DW-1:LSB]) begin
							notify = 1'b1;
						end
						tx_control_n = write_data;
					end
					urxwm_pkg::REG_RXCTRL: begin
						if (write_data[DW-1:LSB] < rx_control_q[DW-1:LSB]) begin
							notify = 1'b1;
						end
						rx_control_n = write_data;
					end
					urxwm_pkg::REG_IE:  int_enable_n = write_data;
					urxwm_pkg::REG_DIV: divisor_n    = write_data;
					default: ;
				endcase
				// an ie write defers the re-evaluation
				if (reg_index == urxwm_pkg::REG_IE) begin
					res.kick_delayed = 1'b1;
				end else begin
					res.kick_now = notify;
				end
			end
			urxwm_pkg::FUNC_RX_BYTE: begin
				if (fifo_full) begin
					res.rx_dropped = 1'b1;
				end else begin
					push = 1'b1;
				end
			end
			default: ;
		endcase

		if (pop) begin
			count_n = fifo_count - CNT_W'(1);
		end else if (push) begin
			count_n = fifo_count + CNT_W'(1);
		end else begin
			count_n = fifo_count;
		end

		// irq condition on the state after this request
		res.irq_condition = int_enable_n[urxwm_pkg::IE_TXWM_BIT] ||
			(int_enable_n[urxwm_pkg::IE_RXWM_BIT] &&
			 (DW'(count_n) > DW'(rx_control_n[DW-1:LSB])));

		cmd.push = accept && push;
		cmd.pop  = accept && pop;
		cmd.data = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_control_q <= '0;
			rx_control_q <= '0;
			int_enable_q <= '0;
			divisor_q    <= '0;
		end else if (accept) begin
			tx_control_q <= tx_control_n;
			rx_control_q <= rx_control_n;
			int_enable_q <= int_enable_n;
			divisor_q    <= divisor_n;
		end
	end

	// output register drains first; skid catches a request while it stalls
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q};

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q) else $error("skid holds result ahead of output");

	a_one_kick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.kick_now && out_q.kick_delayed))
		else $error("both kicks raised");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

`default_nettype wire
